[src/crc32w_pkg.sv]
// Package for the word-serial CRC-32 engine: widths, polynomial, the 32-step
// XOR matrix built at elaboration, byte-keep mask and shared structs.
// No dependencies.
package crc32w_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned CntWidth  = 3;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C11DB7;

  typedef logic [CrcWidth-1:0] crc_t;
  typedef logic [CrcWidth-1:0][CrcWidth-1:0] crc_mat_t;

  // Word request held in the input register.
  typedef struct packed {
    logic last;
    crc_t word;
  } word_req_t;

  // Step request from the pipeline to the CRC state.
  typedef struct packed {
    logic fire;
    logic last;
    crc_t word;
  } step_t;

  // Row i holds the set of state bits that XOR into bit i after 32 shifts.
  function automatic crc_mat_t crc_matrix();
    crc_mat_t m;
    crc_t     v;
    m = '0;
    for (int j = 0; j < CrcWidth; j++) begin
      v = crc_t'(1) << j;
      for (int k = 0; k < CrcWidth; k++) begin
        v = v[CrcWidth-1] ? ((v << 1) ^ CrcPoly) : (v << 1);
      end
      for (int i = 0; i < CrcWidth; i++) begin
        m[i][j] = v[i];
      end
    end
    return m;
  endfunction

  localparam crc_mat_t CrcMatrix = crc_matrix();

  // Four MSB-first byte steps equal 32 bit steps on (crc ^ word).
  function automatic crc_t crc_word_step(crc_t x);
    crc_t r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = ^(x & CrcMatrix[i]);
    end
    return r;
  endfunction

  function automatic crc_t keep_mask(logic [CntWidth-1:0] n);
    crc_t r;
    case (n)
      3'd0:    r = 32'h0000_0000;
      3'd1:    r = 32'h0000_00FF;
      3'd2:    r = 32'h0000_FFFF;
      3'd3:    r = 32'h00FF_FFFF;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

[src/crc32_word_engine.sv]
// Top level of the word-serial CRC-32 engine (poly 0x04C11DB7, MSB first).
// Depends on crc32w_pkg, crc32w_in_stage and crc32w_crc_state.
//
// Usage:
//   s_axis carries message words: tdata holds data_word in bits 31..0 and
//   valid_bytes in bits 34..32 (upper bits unused); tlast marks the last word.
//   m_axis returns one result per word: tdata is the inverted running CRC,
//   tlast is set on the result that closes the message.
//   cfg_valid_i/cfg_data_i write the initial CRC value; the running register
//   reloads with its inverse at once. Write only while no word is in flight.
// Path: a request accepted into the input register is then taken into
//   the result register and shown on m_axis from there.
// Throughput: one word per cycle unless m_axis stalls; the four byte steps
//   are a single XOR matrix between the input register and result register.
// Reset: both stages empty, init value 0, CRC register all ones.
// Stall: while m_axis_tready is low the result holds, the input register
//   still fills once, then s_axis_tready drops until the result is taken.
module crc32_word_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // data_word, valid_bytes
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // crc_value
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned W = crc32w_pkg::CrcWidth;
  localparam int unsigned C = crc32w_pkg::CntWidth;

  logic                  s1_valid;
  crc32w_pkg::word_req_t s1_req;
  logic                  s1_move;
  logic                  out_ready;
  logic                  cfg_fire;
  crc32w_pkg::step_t     step;
  crc32w_pkg::crc_t      crc_next;
  crc32w_pkg::crc_t      crc_state;

  logic                  out_valid_q, out_valid_d;
  crc32w_pkg::crc_t      out_crc_q, out_crc_d;
  logic                  out_last_q, out_last_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign s1_move   = s1_valid && out_ready;

  crc32w_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .word_i    (s_axis_tdata[W-1:0]),
    .bytes_i   (s_axis_tdata[W+C-1:W]),
    .last_i    (s_axis_tlast),
    .advance_i (s1_move),
    .ready_o   (s_axis_tready),
    .valid_o   (s1_valid),
    .req_o     (s1_req)
  );

  assign step.fire = s1_move;
  assign step.last = s1_req.last;
  assign step.word = s1_req.word;

  crc32w_crc_state u_crc_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_fire_i  (cfg_fire),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .crc_next_o  (crc_next),
    .crc_state_o (crc_state)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_crc_d   = out_crc_q;
    out_last_d  = out_last_q;
    if (out_ready) begin
      out_valid_d = s1_valid;
    end
    if (s1_move) begin
      out_crc_d  = ~crc_next;
      out_last_d = s1_req.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_crc_q  <= out_crc_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;
  assign m_axis_tlast  = out_last_q;

  a_move_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> m_axis_tvalid)
    else $error("word left input register but no result was shown");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s1_valid) |-> s1_move)
    else $error("request accepted into a full input register");

  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (crc_state == ~$past(cfg_data_i)))
    else $error("CRC register did not reload on init write");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result overwritten while stalled");

endmodule

[src/crc32w_in_stage.sv]
// Input register of the CRC engine: takes a word request, masks the
// invalid upper bytes and holds it until the next stage takes it.
// Depends on crc32w_pkg.
module crc32w_in_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  crc32w_pkg::crc_t                    word_i,
  input  logic [crc32w_pkg::CntWidth-1:0]     bytes_i,
  input  logic                                last_i,
  input  logic                                advance_i,
  output logic                                ready_o,
  output logic                                valid_o,
  output crc32w_pkg::word_req_t               req_o
);

  logic                  valid_q, valid_d;
  crc32w_pkg::word_req_t req_q, req_d;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    req_d = req_q;
    if (valid_i && ready_o) begin
      req_d.word = word_i & crc32w_pkg::keep_mask(bytes_i);
      req_d.last = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

[src/crc32w_crc_state.sv]
// Running CRC register and init value register of the CRC engine, with the
// one-word XOR-matrix update. Depends on crc32w_pkg.
module crc32w_crc_state (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_fire_i,
  input  crc32w_pkg::crc_t       cfg_data_i,
  input  crc32w_pkg::step_t      step_i,
  output crc32w_pkg::crc_t       crc_next_o,
  output crc32w_pkg::crc_t       crc_state_o
);

  crc32w_pkg::crc_t init_q, init_d;
  crc32w_pkg::crc_t crc_q, crc_d;
  crc32w_pkg::crc_t crc_next;

  assign crc_next = crc32w_pkg::crc_word_step(crc_q ^ step_i.word);

  always_comb begin
    init_d = init_q;
    crc_d  = crc_q;
    if (cfg_fire_i) begin
      init_d = cfg_data_i;
      crc_d  = ~cfg_data_i;
    end else if (step_i.fire) begin
      crc_d = step_i.last ? ~init_q : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      crc_q  <= '1;
    end else begin
      init_q <= init_d;
      crc_q  <= crc_d;
    end
  end

  assign crc_next_o  = crc_next;
  assign crc_state_o = crc_q;

endmodule
